// ===== rtl/tpos_pkg.sv =====
`timescale 1ns / 1ps
package tpos_pkg;
    localparam int NUM_TIMERS = 16;
    localparam int TICK_WIDTH = 32;
    localparam int ID_W = 4;
    localparam int SLOT_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    localparam logic [2:0] MODE_TICK   = 3'd0;
    localparam logic [2:0] MODE_CREATE = 3'd1;
    localparam logic [2:0] MODE_DELETE = 3'd2;
    localparam logic [2:0] MODE_START  = 3'd3;
    localparam logic [2:0] MODE_STOP   = 3'd4;
    localparam logic [2:0] MODE_REM    = 3'd5;
    localparam logic [2:0] MODE_STATE  = 3'd6;
    localparam logic [2:0] MODE_UNDEF  = 3'd7;

    localparam logic [2:0] STS_OK       = 3'd0;
    localparam logic [2:0] STS_BAD_OPT  = 3'd1;
    localparam logic [2:0] STS_BAD_DLY  = 3'd2;
    localparam logic [2:0] STS_NO_FREE  = 3'd3;
    localparam logic [2:0] STS_INACTIVE = 3'd4;
    localparam logic [2:0] STS_STOPPED  = 3'd5;

    localparam logic [1:0] SL_UNUSED    = 2'd0;
    localparam logic [1:0] SL_STOPPED   = 2'd1;
    localparam logic [1:0] SL_RUNNING   = 2'd2;
    localparam logic [1:0] SL_COMPLETED = 2'd3;

    localparam logic [1:0] KIND_ONESHOT  = 2'd1;
    localparam logic [1:0] KIND_PERIODIC = 2'd2;
    localparam logic [1:0] ACT_NONE      = 2'd0;
    localparam logic [1:0] ACT_INVALID   = 2'd3;

    typedef logic [TICK_WIDTH-1:0] tick_t;

    // shared adder operation select
    typedef enum logic [1:0] {
        ALU_ADD = 2'd0,
        ALU_SUB = 2'd1,
        ALU_INC = 2'd2
    } alu_op_t;

    typedef struct packed {
        alu_op_t op;
        tick_t   a;
        tick_t   b;
    } alu_req_t;
endpackage

// ===== rtl/tpos_alu.sv =====
`timescale 1ns / 1ps
module tpos_alu
(
    input  tpos_pkg::alu_req_t req,
    output tpos_pkg::tick_t    res
);
    // single shared add / subtract unit
    always_comb
    begin
        case (req.op)
            tpos_pkg::ALU_ADD: res = req.a + req.b;
            tpos_pkg::ALU_SUB: res = req.a - req.b;
            tpos_pkg::ALU_INC: res = req.a + tpos_pkg::tick_t'(1);
            default:           res = req.a;
        endcase
    end
endmodule

// ===== rtl/timer_pool_one_shot_periodic_core.sv =====
`timescale 1ns / 1ps
// channel | direction | signals
// command | in        | start, busy, mode, timer_sel, delay_ticks, period_ticks,
//         |           | timer_kind, stop_action
// result  | out       | strobe, status, slot_id, remaining, slot_state, fired, last
// a tick keeps busy high while it walks the slots one at a time through
// one shared adder (compare, re-arm, remaining); create scans the slots for a free one.
// other commands step through command, remaining and output; a start may also arm.
// the final result word shows in the same cycle that busy falls, and a new command
// may be accepted in that same cycle. reset clears the slot states and the counter;
// the result receiver cannot stall.
module timer_pool_one_shot_periodic_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  mode,
    input  logic [3:0]  timer_sel,
    input  logic [31:0] delay_ticks,
    input  logic [31:0] period_ticks,
    input  logic [1:0]  timer_kind,
    input  logic [1:0]  stop_action,
    output logic        strobe,
    output logic [2:0]  status,
    output logic [3:0]  slot_id,
    output logic [31:0] remaining,
    output logic [1:0]  slot_state,
    output logic        fired,
    output logic        last
);
    localparam int N = tpos_pkg::NUM_TIMERS;
    localparam int SW = tpos_pkg::SLOT_W;
    localparam int TW = tpos_pkg::TICK_WIDTH;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_TINC  = 4'd1;
    localparam logic [3:0] S_TCHK  = 4'd2;
    localparam logic [3:0] S_TARM  = 4'd3;
    localparam logic [3:0] S_TREM  = 4'd4;
    localparam logic [3:0] S_CSCAN = 4'd5;
    localparam logic [3:0] S_CMD   = 4'd6;
    localparam logic [3:0] S_ARM   = 4'd7;
    localparam logic [3:0] S_REM   = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;
    localparam logic [3:0] S_TFLUSH = 4'd10;

    logic [3:0]  state_reg, state_next;
    logic [1:0]  slot_st_reg [N];
    logic [N-1:0] slot_per_reg;
    tpos_pkg::tick_t slot_dly_mem [N];
    tpos_pkg::tick_t slot_prd_mem [N];
    tpos_pkg::tick_t slot_mat_mem [N];
    tpos_pkg::tick_t tick_reg;

    logic [2:0]  mode_reg;
    logic [3:0]  id_reg;
    logic [31:0] dly_reg, prd_reg;
    logic [1:0]  kind_reg, act_reg;
    logic [SW:0] idx_reg;
    logic [4:0]  nres_reg;
    tpos_pkg::tick_t acc_reg;

    // pending tick result held until the next one or the end of the scan
    logic        pend_reg;
    logic [3:0]  pid_reg;
    logic [31:0] prem_reg;
    logic [1:0]  pst_reg;

    logic        o_stb_reg, o_fired_reg, o_last_reg;
    logic [2:0]  o_sts_reg;
    logic [3:0]  o_id_reg;
    logic [31:0] o_rem_reg;
    logic [1:0]  o_sst_reg;

    tpos_pkg::alu_req_t alu_req;
    tpos_pkg::tick_t    alu_res;

    logic [SW-1:0] si;
    logic [SW-1:0] cid;
    logic          cvalid;
    logic [1:0]    ccur;

    assign si = idx_reg[SW-1:0];
    assign cvalid = ({28'd0, id_reg} < N);
    assign cid = id_reg[SW-1:0];
    assign ccur = cvalid ? slot_st_reg[cid] : tpos_pkg::SL_UNUSED;

    tpos_alu u_alu (.req(alu_req), .res(alu_res));

    // adder operand select per step
    always_comb
    begin
        alu_req.op = tpos_pkg::ALU_ADD;
        alu_req.a  = tick_reg;
        alu_req.b  = '0;
        case (state_reg)
            S_TINC: alu_req.op = tpos_pkg::ALU_INC;
            S_TCHK:
            begin
                alu_req.op = tpos_pkg::ALU_SUB;
                alu_req.a  = slot_mat_mem[si];
                alu_req.b  = tick_reg;
            end
            S_TARM: alu_req.b = slot_prd_mem[si];
            S_TREM, S_REM:
            begin
                alu_req.op = tpos_pkg::ALU_SUB;
                alu_req.a  = (state_reg == S_TREM) ? acc_reg : slot_mat_mem[cid];
                alu_req.b  = tick_reg;
            end
            S_ARM:
            begin
                alu_req.b = (slot_per_reg[cid] && slot_dly_mem[cid] == '0)
                            ? slot_prd_mem[cid] : slot_dly_mem[cid];
            end
            default: alu_req.op = tpos_pkg::ALU_ADD;
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign strobe = o_stb_reg;
    assign status = o_sts_reg;
    assign slot_id = o_id_reg;
    assign remaining = o_rem_reg;
    assign slot_state = o_sst_reg;
    assign fired = o_fired_reg;
    assign last = o_last_reg;

    // sequencer and slot state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            tick_reg <= '0;
            slot_per_reg <= '0;
            for (int i = 0; i < N; i++)
            begin
                slot_st_reg[i] <= tpos_pkg::SL_UNUSED;
            end
            o_stb_reg <= 1'b0;
            pend_reg <= 1'b0;
            idx_reg <= '0;
            nres_reg <= '0;
        end
        else
        begin
            o_stb_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        mode_reg <= mode;
                        id_reg <= timer_sel;
                        dly_reg <= delay_ticks;
                        prd_reg <= period_ticks;
                        kind_reg <= timer_kind;
                        act_reg <= stop_action;
                        idx_reg <= '0;
                        nres_reg <= '0;
                        pend_reg <= 1'b0;
                        if (mode == tpos_pkg::MODE_TICK)
                            state_reg <= S_TINC;
                        else if (mode == tpos_pkg::MODE_CREATE)
                            state_reg <= S_CSCAN;
                        else if (mode == tpos_pkg::MODE_UNDEF)
                            state_reg <= S_IDLE;
                        else
                            state_reg <= S_CMD;
                    end
                end
                S_TINC:
                begin
                    tick_reg <= alu_res;
                    state_reg <= S_TCHK;
                end
                S_TCHK:
                begin
                    if (idx_reg == N[SW:0])
                        state_reg <= S_TFLUSH;
                    else if (slot_st_reg[si] == tpos_pkg::SL_RUNNING && alu_res == '0)
                    begin
                        if (slot_per_reg[si])
                            state_reg <= S_TARM;
                        else
                        begin
                            slot_st_reg[si] <= tpos_pkg::SL_COMPLETED;
                            acc_reg <= tick_reg;
                            state_reg <= S_TREM;
                        end
                    end
                    else
                        idx_reg <= idx_reg + 1'b1;
                end
                S_TARM:
                begin
                    slot_mat_mem[si] <= alu_res;
                    acc_reg <= alu_res;
                    state_reg <= S_TREM;
                end
                S_TREM:
                begin
                    // emit the previous pending word, keep this one
                    if (nres_reg < 5'd16)
                    begin
                        if (pend_reg)
                        begin
                            o_stb_reg <= 1'b1;
                            o_sts_reg <= tpos_pkg::STS_OK;
                            o_id_reg <= pid_reg;
                            o_rem_reg <= prem_reg;
                            o_sst_reg <= pst_reg;
                            o_fired_reg <= 1'b1;
                            o_last_reg <= 1'b0;
                        end
                        pend_reg <= 1'b1;
                        pid_reg <= 4'(idx_reg);
                        prem_reg <= 32'(alu_res);
                        pst_reg <= slot_st_reg[si];
                        nres_reg <= nres_reg + 1'b1;
                    end
                    idx_reg <= idx_reg + 1'b1;
                    state_reg <= S_TCHK;
                end
                S_TFLUSH:
                begin
                    if (pend_reg)
                    begin
                        o_stb_reg <= 1'b1;
                        o_sts_reg <= tpos_pkg::STS_OK;
                        o_id_reg <= pid_reg;
                        o_rem_reg <= prem_reg;
                        o_sst_reg <= pst_reg;
                        o_fired_reg <= 1'b1;
                        o_last_reg <= 1'b1;
                    end
                    pend_reg <= 1'b0;
                    state_reg <= S_IDLE;
                end
                S_CSCAN:
                begin
                    o_id_reg <= '0;
                    o_rem_reg <= '0;
                    o_fired_reg <= 1'b0;
                    o_last_reg <= 1'b1;
                    if (kind_reg != tpos_pkg::KIND_ONESHOT &&
                        kind_reg != tpos_pkg::KIND_PERIODIC)
                    begin
                        o_stb_reg <= 1'b1;
                        o_sts_reg <= tpos_pkg::STS_BAD_OPT;
                        o_sst_reg <= tpos_pkg::SL_UNUSED;
                        state_reg <= S_IDLE;
                    end
                    else if ((kind_reg == tpos_pkg::KIND_ONESHOT && dly_reg == '0) ||
                             (kind_reg == tpos_pkg::KIND_PERIODIC && prd_reg == '0))
                    begin
                        o_stb_reg <= 1'b1;
                        o_sts_reg <= tpos_pkg::STS_BAD_DLY;
                        o_sst_reg <= tpos_pkg::SL_UNUSED;
                        state_reg <= S_IDLE;
                    end
                    else if (idx_reg == N[SW:0])
                    begin
                        o_stb_reg <= 1'b1;
                        o_sts_reg <= tpos_pkg::STS_NO_FREE;
                        o_sst_reg <= tpos_pkg::SL_UNUSED;
                        state_reg <= S_IDLE;
                    end
                    else if (slot_st_reg[si] == tpos_pkg::SL_UNUSED)
                    begin
                        slot_st_reg[si] <= tpos_pkg::SL_STOPPED;
                        slot_per_reg[si] <= (kind_reg == tpos_pkg::KIND_PERIODIC);
                        slot_dly_mem[si] <= TW'(dly_reg);
                        slot_prd_mem[si] <= TW'(prd_reg);
                        slot_mat_mem[si] <= '0;
                        o_stb_reg <= 1'b1;
                        o_sts_reg <= tpos_pkg::STS_OK;
                        o_id_reg <= 4'(idx_reg);
                        o_sst_reg <= tpos_pkg::SL_STOPPED;
                        state_reg <= S_IDLE;
                    end
                    else
                        idx_reg <= idx_reg + 1'b1;
                end
                S_CMD:
                begin
                    o_sts_reg <= tpos_pkg::STS_OK;
                    o_fired_reg <= 1'b0;
                    state_reg <= S_REM;
                    case (mode_reg)
                        tpos_pkg::MODE_DELETE:
                        begin
                            if (ccur == tpos_pkg::SL_UNUSED)
                                o_sts_reg <= tpos_pkg::STS_INACTIVE;
                            else
                            begin
                                slot_st_reg[cid] <= tpos_pkg::SL_UNUSED;
                                slot_per_reg[cid] <= 1'b0;
                            end
                        end
                        tpos_pkg::MODE_START:
                        begin
                            if (ccur == tpos_pkg::SL_UNUSED)
                                o_sts_reg <= tpos_pkg::STS_INACTIVE;
                            else if (ccur != tpos_pkg::SL_RUNNING)
                                state_reg <= S_ARM;
                        end
                        tpos_pkg::MODE_STOP:
                        begin
                            if (ccur == tpos_pkg::SL_UNUSED)
                                o_sts_reg <= tpos_pkg::STS_INACTIVE;
                            else if (act_reg == tpos_pkg::ACT_INVALID)
                                o_sts_reg <= tpos_pkg::STS_BAD_OPT;
                            else if (ccur == tpos_pkg::SL_STOPPED)
                                o_sts_reg <= tpos_pkg::STS_STOPPED;
                            else
                            begin
                                slot_st_reg[cid] <= tpos_pkg::SL_STOPPED;
                                o_fired_reg <= (act_reg != tpos_pkg::ACT_NONE);
                            end
                        end
                        tpos_pkg::MODE_REM:
                        begin
                            if (ccur == tpos_pkg::SL_UNUSED)
                                o_sts_reg <= tpos_pkg::STS_INACTIVE;
                        end
                        default: o_sts_reg <= tpos_pkg::STS_OK;
                    endcase
                end
                S_ARM:
                begin
                    slot_mat_mem[cid] <= alu_res;
                    slot_st_reg[cid] <= tpos_pkg::SL_RUNNING;
                    state_reg <= S_REM;
                end
                S_REM:
                begin
                    o_rem_reg <= (ccur == tpos_pkg::SL_RUNNING) ? 32'(alu_res) : '0;
                    o_sst_reg <= ccur;
                    o_id_reg <= id_reg;
                    o_last_reg <= 1'b1;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    o_stb_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(busy))
        else $error("result without command");
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (!busy && !$past(busy)) |-> !strobe)
        else $error("strobe while idle");
    a_fire_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && fired) |-> (status == tpos_pkg::STS_OK))
        else $error("fired with error status");
    a_err_unused: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && status == tpos_pkg::STS_INACTIVE) |->
        (slot_state == tpos_pkg::SL_UNUSED && remaining == '0))
        else $error("inactive word carries state");
`endif
endmodule

// ===== dv/timer_pool_one_shot_periodic_core_tb.sv =====
`timescale 1ns / 1ps
module timer_pool_one_shot_periodic_core_tb;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  slot_id;
        logic [31:0] remaining;
        logic [1:0]  slot_state;
        logic        fired;
        logic        last;
    } timer_word_t;

    // expected results and a shadow copy of the pool
    class timer_board;
        timer_word_t pending[$];
        int          errors;
        logic [31:0] ticks;
        logic [1:0]  st[tpos_pkg::NUM_TIMERS];
        logic        per_en[tpos_pkg::NUM_TIMERS];
        logic [31:0] dly[tpos_pkg::NUM_TIMERS];
        logic [31:0] per[tpos_pkg::NUM_TIMERS];
        logic [31:0] match[tpos_pkg::NUM_TIMERS];

        function new();
            errors = 0;
            ticks = '0;
            for (int i = 0; i < tpos_pkg::NUM_TIMERS; i++)
            begin
                st[i] = tpos_pkg::SL_UNUSED;
                per_en[i] = 1'b0;
                dly[i] = '0;
                per[i] = '0;
                match[i] = '0;
            end
        endfunction

        function logic [31:0] left_of(int s);
            if (st[s] != tpos_pkg::SL_RUNNING)
                return '0;
            return match[s] - ticks;
        endfunction

        function void push(logic [2:0] s, int id, logic [31:0] r, logic [1:0] ss,
                           logic f, logic l);
            timer_word_t w;
            w.status = s;
            w.slot_id = id[3:0];
            w.remaining = r;
            w.slot_state = ss;
            w.fired = f;
            w.last = l;
            pending.push_back(w);
        endfunction

        // note one accepted command word
        function void note_command(logic [2:0] md, logic [3:0] id, logic [31:0] d,
                                   logic [31:0] p, logic [1:0] kd, logic [1:0] act);
            logic [2:0] sts;
            logic       fr;
            int         n;
            int         fi;
            sts = tpos_pkg::STS_OK;
            fr = 1'b0;
            n = 0;
            fi = -1;
            case (md)
                tpos_pkg::MODE_TICK:
                begin
                    ticks = ticks + 1;
                    for (int i = 0; i < tpos_pkg::NUM_TIMERS; i++)
                    begin
                        if (st[i] == tpos_pkg::SL_RUNNING && match[i] == ticks)
                        begin
                            if (per_en[i])
                                match[i] = ticks + per[i];
                            else
                                st[i] = tpos_pkg::SL_COMPLETED;
                            if (n < 16)
                            begin
                                push(tpos_pkg::STS_OK, i, left_of(i), st[i], 1'b1, 1'b0);
                                n++;
                            end
                        end
                    end
                    if (n > 0)
                        pending[pending.size()-1].last = 1'b1;
                    return;
                end
                tpos_pkg::MODE_CREATE:
                begin
                    if (kd != tpos_pkg::KIND_ONESHOT && kd != tpos_pkg::KIND_PERIODIC)
                        sts = tpos_pkg::STS_BAD_OPT;
                    else if ((kd == tpos_pkg::KIND_ONESHOT && d == 0) ||
                             (kd == tpos_pkg::KIND_PERIODIC && p == 0))
                        sts = tpos_pkg::STS_BAD_DLY;
                    else
                    begin
                        for (int i = tpos_pkg::NUM_TIMERS - 1; i >= 0; i--)
                            if (st[i] == tpos_pkg::SL_UNUSED)
                                fi = i;
                        if (fi < 0)
                            sts = tpos_pkg::STS_NO_FREE;
                    end
                    if (fi >= 0)
                    begin
                        st[fi] = tpos_pkg::SL_STOPPED;
                        per_en[fi] = (kd == tpos_pkg::KIND_PERIODIC);
                        dly[fi] = d;
                        per[fi] = p;
                        match[fi] = '0;
                        push(tpos_pkg::STS_OK, fi, '0, tpos_pkg::SL_STOPPED, 1'b0, 1'b1);
                    end
                    else
                        push(sts, 0, '0, tpos_pkg::SL_UNUSED, 1'b0, 1'b1);
                    return;
                end
                tpos_pkg::MODE_DELETE:
                    if (st[id] == tpos_pkg::SL_UNUSED)
                        sts = tpos_pkg::STS_INACTIVE;
                    else
                    begin
                        st[id] = tpos_pkg::SL_UNUSED;
                        per_en[id] = 1'b0;
                        dly[id] = '0;
                        per[id] = '0;
                        match[id] = '0;
                    end
                tpos_pkg::MODE_START:
                    if (st[id] == tpos_pkg::SL_UNUSED)
                        sts = tpos_pkg::STS_INACTIVE;
                    else if (st[id] != tpos_pkg::SL_RUNNING)
                    begin
                        match[id] = ticks + ((per_en[id] && dly[id] == 0) ? per[id] : dly[id]);
                        st[id] = tpos_pkg::SL_RUNNING;
                    end
                tpos_pkg::MODE_STOP:
                    if (st[id] == tpos_pkg::SL_UNUSED)
                        sts = tpos_pkg::STS_INACTIVE;
                    else if (act == tpos_pkg::ACT_INVALID)
                        sts = tpos_pkg::STS_BAD_OPT;
                    else if (st[id] == tpos_pkg::SL_STOPPED)
                        sts = tpos_pkg::STS_STOPPED;
                    else
                    begin
                        st[id] = tpos_pkg::SL_STOPPED;
                        fr = (act != tpos_pkg::ACT_NONE);
                    end
                tpos_pkg::MODE_REM:
                    if (st[id] == tpos_pkg::SL_UNUSED)
                        sts = tpos_pkg::STS_INACTIVE;
                tpos_pkg::MODE_STATE: ;
                default: return;
            endcase
            push(sts, id, left_of(id), st[id], fr, 1'b1);
        endfunction

        // compare one result word with the oldest expectation
        function void check_result(timer_word_t got);
            timer_word_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result word status=%0d slot=%0d", got.status, got.slot_id);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.status !== e.status)
            begin
                $error("status expected %0d actual %0d", e.status, got.status);
                errors++;
            end
            if (got.slot_id !== e.slot_id)
            begin
                $error("slot_id expected %0d actual %0d", e.slot_id, got.slot_id);
                errors++;
            end
            if (got.remaining !== e.remaining)
            begin
                $error("remaining expected %0h actual %0h", e.remaining, got.remaining);
                errors++;
            end
            if (got.slot_state !== e.slot_state)
            begin
                $error("slot_state expected %0d actual %0d", e.slot_state, got.slot_state);
                errors++;
            end
            if (got.fired !== e.fired)
            begin
                $error("fired expected %0d actual %0d", e.fired, got.fired);
                errors++;
            end
            if (got.last !== e.last)
            begin
                $error("last expected %0d actual %0d", e.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  mode;
    logic [3:0]  timer_sel;
    logic [31:0] delay_ticks;
    logic [31:0] period_ticks;
    logic [1:0]  timer_kind;
    logic [1:0]  stop_action;
    logic        strobe;
    logic [2:0]  status;
    logic [3:0]  slot_id;
    logic [31:0] remaining;
    logic [1:0]  slot_state;
    logic        fired;
    logic        last;

    timer_board board;
    int         cycles;
    int         n_words;
    int         n_results;
    bit         quiet;

    timer_pool_one_shot_periodic_core dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .mode(mode),
        .timer_sel(timer_sel), .delay_ticks(delay_ticks), .period_ticks(period_ticks),
        .timer_kind(timer_kind), .stop_action(stop_action), .strobe(strobe),
        .status(status), .slot_id(slot_id), .remaining(remaining),
        .slot_state(slot_state), .fired(fired), .last(last)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // result monitor and timeout
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n && strobe)
        begin
            board.check_result({status, slot_id, remaining, slot_state, fired, last});
            n_results <= n_results + 1;
        end
        if (cycles > 400000)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // send one command word, with an optional idle burst first
    task automatic send_word(logic [2:0] md, logic [3:0] id, logic [31:0] d,
                             logic [31:0] p, logic [1:0] kd, logic [1:0] act);
        int gap;
        if (!quiet && $urandom_range(0, 2) == 0)
        begin
            gap = $urandom_range(1, 6);
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        mode <= md;
        timer_sel <= id;
        delay_ticks <= d;
        period_ticks <= p;
        timer_kind <= kd;
        stop_action <= act;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        board.note_command(md, id, d, p, kd, act);
        n_words++;
        start <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain_results();
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    // random delay: zero, all ones, any value, or often a small one so timers actually expire
    function automatic logic [31:0] pick_delay();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'hFFFFFFFF;
            2: return $urandom();
            default: return $urandom_range(1, 5);
        endcase
    endfunction

    initial
    begin
        logic [2:0] md;
        board = new();
        cycles = 0;
        n_words = 0;
        n_results = 0;
        quiet = 0;
        rst_n = 1'b0;
        start = 1'b0;
        mode = tpos_pkg::MODE_TICK;
        timer_sel = '0;
        delay_ticks = '0;
        period_ticks = '0;
        timer_kind = '0;
        stop_action = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: errors, extremes, each command
        send_word(tpos_pkg::MODE_TICK, 0, 0, 0, 0, 0);
        send_word(tpos_pkg::MODE_CREATE, 0, 5, 5, 2'd0, 0);
        send_word(tpos_pkg::MODE_CREATE, 0, 5, 5, 2'd3, 0);
        send_word(tpos_pkg::MODE_CREATE, 0, 0, 5, tpos_pkg::KIND_ONESHOT, 0);
        send_word(tpos_pkg::MODE_CREATE, 0, 5, 0, tpos_pkg::KIND_PERIODIC, 0);
        send_word(tpos_pkg::MODE_DELETE, 4'd15, 0, 0, 0, 0);
        send_word(tpos_pkg::MODE_START, 4'd15, 0, 0, 0, 0);
        send_word(tpos_pkg::MODE_STOP, 4'd15, 0, 0, 0, 0);
        send_word(tpos_pkg::MODE_REM, 4'd15, 0, 0, 0, 0);
        send_word(tpos_pkg::MODE_STATE, 4'd15, 0, 0, 0, 0);
        send_word(tpos_pkg::MODE_CREATE, 0, 1, 32'hFFFFFFFF, tpos_pkg::KIND_ONESHOT, 0);
        send_word(tpos_pkg::MODE_CREATE, 0, 0, 2, tpos_pkg::KIND_PERIODIC, 0);
        send_word(tpos_pkg::MODE_CREATE, 0, 32'hFFFFFFFF, 1, tpos_pkg::KIND_PERIODIC, 0);
        send_word(tpos_pkg::MODE_STOP, 0, 0, 0, 0, 0);
        send_word(tpos_pkg::MODE_START, 0, 0, 0, 0, 0);
        send_word(tpos_pkg::MODE_START, 1, 0, 0, 0, 0);
        send_word(tpos_pkg::MODE_START, 1, 0, 0, 0, 0);
        send_word(tpos_pkg::MODE_START, 2, 0, 0, 0, 0);
        send_word(tpos_pkg::MODE_STOP, 2, 0, 0, 0, tpos_pkg::ACT_INVALID);
        send_word(tpos_pkg::MODE_REM, 2, 0, 0, 0, 0);
        send_word(tpos_pkg::MODE_TICK, 0, 32'hFFFFFFFF, 32'hFFFFFFFF, 3, 3);
        send_word(tpos_pkg::MODE_TICK, 0, 0, 0, 0, 0);
        send_word(tpos_pkg::MODE_STOP, 0, 0, 0, 0, 2'd1);
        send_word(tpos_pkg::MODE_STOP, 1, 0, 0, 0, 2'd2);
        send_word(tpos_pkg::MODE_UNDEF, 4'd3, 0, 0, 0, 0);
        send_word(tpos_pkg::MODE_DELETE, 0, 0, 0, 0, 0);
        // fill the pool, then overflow it
        for (int i = 0; i < tpos_pkg::NUM_TIMERS + 1; i++)
            send_word(tpos_pkg::MODE_CREATE, 0, $urandom_range(1, 3), $urandom_range(1, 3),
                      $urandom_range(1, 2), 0);
        for (int i = 0; i < tpos_pkg::NUM_TIMERS; i++)
            send_word(tpos_pkg::MODE_START, i[3:0], 0, 0, 0, 0);
        for (int i = 0; i < 4; i++)
            send_word(tpos_pkg::MODE_TICK, 0, 0, 0, 0, 0);
        // sender holds off until the pool has answered everything
        drain_results();

        // random mix, weighted toward ticks and lifecycle commands
        for (int k = 0; k < 40; k++)
        begin
            if (k == 30)
                quiet = 1;
            case ($urandom_range(0, 9))
                0, 1, 2: md = tpos_pkg::MODE_TICK;
                3: md = tpos_pkg::MODE_CREATE;
                4: md = tpos_pkg::MODE_DELETE;
                5, 6: md = tpos_pkg::MODE_START;
                7: md = tpos_pkg::MODE_STOP;
                8: md = tpos_pkg::MODE_REM;
                default: md = ($urandom_range(0, 5) == 0) ? tpos_pkg::MODE_UNDEF
                                                          : tpos_pkg::MODE_STATE;
            endcase
            send_word(md, $urandom_range(0, 15), pick_delay(), pick_delay(),
                      $urandom_range(0, 3), $urandom_range(0, 3));
        end

        drain_results();
        $display("sent %0d command words, %0d result words checked", n_words, n_results);
        $display("covered create errors, full pool, stops, queries and timer expiries");
        if (board.errors == 0 && board.pending.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
